/* hdl/cc20ks_pkg.sv */
// shared types, constants and the sequencer microcode for the chacha20 keystream block
// used by cc20ks_core and chacha20_keystream_xor; depends on nothing
`default_nettype none

package cc20ks_pkg;

    localparam int unsigned KEY_REGS    = 4;
    localparam int unsigned ADDR_W      = 5;
    localparam int unsigned ROUND_PAIRS = 10;
    localparam int unsigned ROUND_W     = $clog2(ROUND_PAIRS);
    localparam int unsigned STEP_W      = 4;

    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;

    typedef logic [KEY_REGS-1:0][63:0] key_t;

    // micro-op codes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_QR    = 2'd1;
    localparam logic [1:0] OP_FINAL = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    // quarter-round sub-steps, named by their rotation
    localparam logic [1:0] SUB_R16 = 2'd0;
    localparam logic [1:0] SUB_R12 = 2'd1;
    localparam logic [1:0] SUB_R8  = 2'd2;
    localparam logic [1:0] SUB_R7  = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic [1:0]        sub;
        logic              diag;
        logic              loop_end;
        logic [STEP_W-1:0] target;
    } ucw_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

    // one double round is eight steps: four column sub-steps, four diagonal
    function automatic ucw_t ucode(logic [STEP_W-1:0] step);
        ucw_t cw;
        cw = '{op: OP_NOP, sub: SUB_R16, diag: 1'b0, loop_end: 1'b0, target: '0};
        unique case (step)
            4'd0: cw.op = OP_LOAD;
            4'd1: begin cw.op = OP_QR; cw.sub = SUB_R16; end
            4'd2: begin cw.op = OP_QR; cw.sub = SUB_R12; end
            4'd3: begin cw.op = OP_QR; cw.sub = SUB_R8;  end
            4'd4: begin cw.op = OP_QR; cw.sub = SUB_R7;  end
            4'd5: begin cw.op = OP_QR; cw.sub = SUB_R16; cw.diag = 1'b1; end
            4'd6: begin cw.op = OP_QR; cw.sub = SUB_R12; cw.diag = 1'b1; end
            4'd7: begin cw.op = OP_QR; cw.sub = SUB_R8;  cw.diag = 1'b1; end
            4'd8: begin
                cw.op       = OP_QR;
                cw.sub      = SUB_R7;
                cw.diag     = 1'b1;
                cw.loop_end = 1'b1;
                cw.target   = 4'd1;
            end
            4'd9: cw.op = OP_FINAL;
            default: cw.op = OP_NOP;
        endcase
        return cw;
    endfunction

    function automatic logic [31:0] rotl_sub(logic [31:0] v, logic [1:0] sub);
        logic [31:0] r;
        unique case (sub)
            SUB_R16: r = {v[15:0], v[31:16]};
            SUB_R12: r = {v[19:0], v[31:20]};
            SUB_R8:  r = {v[23:0], v[31:24]};
            SUB_R7:  r = {v[24:0], v[31:25]};
            default: r = v;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/chacha20_keystream_xor.sv */
// top level: apb key registers, record tracking, byte xor and output register
// instantiates cc20ks_core; uses cc20ks_pkg
//
//  channel  ports         width  contents
//  input    s_t*          72+1   data_byte, record_seq, last on s_tlast
//  output   m_t*          8+1    out_byte, out_last on m_tlast
//  config   apb p*        64     key_part0..3 at byte addresses 0, 8, 16, 24
//
// a byte inside a block goes straight to the output register; the first byte of each
// 64-byte block waits for the block function: the sequencer's load, 80 quarter-round
// steps on four shared lanes and final add, then an emit state that registers the result.
// reset is synchronous, active low; it clears the keys and the record state.
// a result waits in the output register while m_tready is low; the next item is
// taken once that register is free or being emptied.
`default_nettype none

module chacha20_keystream_xor (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [71:0]                   s_tdata,  // data_byte[7:0], record_seq[71:8]
    input  wire logic                          s_tlast,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [7:0]                         m_tdata,  // out_byte[7:0]
    output logic                               m_tlast,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [cc20ks_pkg::ADDR_W-1:0] paddr,
    input  wire logic [63:0]                   pwdata,
    output logic [63:0]                        prdata,
    output logic                               pready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_GEN  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    cc20ks_pkg::key_t       key_reg, key_next;
    logic [63:0]            seq_reg, seq_next;
    logic [31:0]            counter_reg, counter_next;
    logic [5:0]             pos_reg, pos_next;
    logic                   in_rec_reg, in_rec_next;
    logic [1:0]             state_reg, state_next;
    logic [7:0]             hold_data_reg, hold_data_next;
    logic                   hold_last_reg, hold_last_next;
    logic [7:0]             m_data_reg, m_data_next;
    logic                   m_last_reg, m_last_next;
    logic                   m_valid_reg, m_valid_next;
    logic                   s_acc, out_free, core_start;
    logic [7:0]             ks_byte;
    cc20ks_pkg::core_stat_t stat;

    assign out_free   = !m_valid_reg || m_tready;
    assign s_tready   = (state_reg == ST_IDLE) && out_free;
    assign s_acc      = s_tvalid && s_tready;
    assign core_start = s_acc && (pos_reg == 6'd0);

    cc20ks_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (core_start),
        .key     (key_reg),
        .counter (counter_reg),
        .seq     (seq_reg),
        .ks_idx  (pos_reg),
        .ks_byte (ks_byte),
        .stat    (stat)
    );

    always_comb begin
        key_next       = key_reg;
        seq_next       = seq_reg;
        counter_next   = counter_reg;
        pos_next       = pos_reg;
        in_rec_next    = in_rec_reg;
        state_next     = state_reg;
        hold_data_next = hold_data_reg;
        hold_last_next = hold_last_reg;
        m_data_next    = m_data_reg;
        m_last_next    = m_last_reg;
        m_valid_next   = m_valid_reg && !m_tready;

        if (psel && penable && pwrite) begin
            key_next[paddr[4:3]] = pwdata;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (!in_rec_reg) begin
                        seq_next    = s_tdata[71:8];
                        in_rec_next = 1'b1;
                    end
                    if (pos_reg == 6'd0) begin
                        // block boundary: make a new block first
                        hold_data_next = s_tdata[7:0];
                        hold_last_next = s_tlast;
                        state_next     = ST_GEN;
                    end else begin
                        m_data_next  = s_tdata[7:0] ^ ks_byte;
                        m_last_next  = s_tlast;
                        m_valid_next = 1'b1;
                        if (s_tlast) begin
                            in_rec_next  = 1'b0;
                            pos_next     = 6'd0;
                            counter_next = 32'd0;
                        end else begin
                            pos_next = pos_reg + 6'd1;
                        end
                    end
                end
            end
            ST_GEN: begin
                if (stat.done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_data_next  = hold_data_reg ^ ks_byte;
                    m_last_next  = hold_last_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    if (hold_last_reg) begin
                        in_rec_next  = 1'b0;
                        pos_next     = 6'd0;
                        counter_next = 32'd0;
                    end else begin
                        pos_next     = 6'd1;
                        counter_next = counter_reg + 32'd1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg     <= '0;
            seq_reg     <= '0;
            counter_reg <= '0;
            pos_reg     <= '0;
            in_rec_reg  <= 1'b0;
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            key_reg     <= key_next;
            seq_reg     <= seq_next;
            counter_reg <= counter_next;
            pos_reg     <= pos_next;
            in_rec_reg  <= in_rec_next;
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        hold_data_reg <= hold_data_next;
        hold_last_reg <= hold_last_next;
        m_data_reg    <= m_data_next;
        m_last_reg    <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign prdata   = key_reg[paddr[4:3]];
    assign pready   = 1'b1;

`ifndef SYNTHESIS
    a_done_in_gen: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.done |-> state_reg == ST_GEN)
        else $error("block function finished outside generation");

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && pos_reg == 6'd0) |=> stat.busy)
        else $error("block start did not launch the sequencer");

    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_rec_reg |-> (pos_reg == 6'd0 && counter_reg == 32'd0))
        else $error("record state not cleared between records");

    a_busy_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.busy |-> !s_tready)
        else $error("item taken while the block function runs");
`endif

endmodule

`default_nettype wire

/* hdl/cc20ks_core.sv */
// chacha20 block function: microcoded sequencer over a 16-word state and four
// quarter-round lanes; holds the finished keystream block; uses cc20ks_pkg
`default_nettype none

module cc20ks_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire cc20ks_pkg::key_t  key,
    input  wire logic [31:0]       counter,
    input  wire logic [63:0]       seq,
    input  wire logic [5:0]        ks_idx,
    output logic [7:0]             ks_byte,
    output cc20ks_pkg::core_stat_t stat
);

    logic                              busy_reg, busy_next;
    logic [cc20ks_pkg::STEP_W-1:0]     step_reg, step_next;
    logic [cc20ks_pkg::ROUND_W-1:0]    round_reg, round_next;
    logic [31:0]                       w_reg [16];
    logic [31:0]                       w_next [16];
    logic [31:0]                       w_qr [16];
    logic [31:0]                       init [16];
    cc20ks_pkg::ucw_t                  cw;

    assign cw = cc20ks_pkg::ucode(step_reg);

    always_comb begin
        init[0]  = cc20ks_pkg::SIGMA0;
        init[1]  = cc20ks_pkg::SIGMA1;
        init[2]  = cc20ks_pkg::SIGMA2;
        init[3]  = cc20ks_pkg::SIGMA3;
        for (int k = 0; k < 4; k++) begin
            init[4 + 2*k] = key[k][31:0];
            init[5 + 2*k] = key[k][63:32];
        end
        init[12] = counter;
        init[13] = 32'd0;
        init[14] = seq[31:0];
        init[15] = seq[63:32];
    end

    // four independent quarter-round lanes, column or diagonal wiring
    always_comb begin
        logic [3:0]  ia, ib, ic, id;
        logic [31:0] sum;
        w_qr = w_reg;
        for (int g = 0; g < 4; g++) begin
            ia = 4'(g);
            if (cw.diag) begin
                ib = 4'(4 + ((g + 1) % 4));
                ic = 4'(8 + ((g + 2) % 4));
                id = 4'(12 + ((g + 3) % 4));
            end else begin
                ib = 4'(4 + g);
                ic = 4'(8 + g);
                id = 4'(12 + g);
            end
            if (!cw.sub[0]) begin
                sum      = w_reg[ia] + w_reg[ib];
                w_qr[ia] = sum;
                w_qr[id] = cc20ks_pkg::rotl_sub(w_reg[id] ^ sum, cw.sub);
            end else begin
                sum      = w_reg[ic] + w_reg[id];
                w_qr[ic] = sum;
                w_qr[ib] = cc20ks_pkg::rotl_sub(w_reg[ib] ^ sum, cw.sub);
            end
        end
    end

    always_comb begin
        busy_next  = busy_reg;
        step_next  = step_reg;
        round_next = round_reg;
        w_next     = w_reg;
        if (!busy_reg) begin
            if (start) begin
                busy_next  = 1'b1;
                step_next  = '0;
                round_next = '0;
            end
        end else begin
            case (cw.op)
                cc20ks_pkg::OP_LOAD:  w_next = init;
                cc20ks_pkg::OP_QR:    w_next = w_qr;
                cc20ks_pkg::OP_FINAL: begin
                    for (int i = 0; i < 16; i++) begin
                        w_next[i] = w_reg[i] + init[i];
                    end
                end
                default: w_next = w_reg;
            endcase
            if (cw.loop_end &&
                round_reg != cc20ks_pkg::ROUND_W'(cc20ks_pkg::ROUND_PAIRS - 1)) begin
                round_next = round_reg + 1'b1;
                step_next  = cw.target;
            end else if (cw.op == cc20ks_pkg::OP_FINAL) begin
                busy_next = 1'b0;
            end else begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            step_reg  <= '0;
            round_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            step_reg  <= step_next;
            round_reg <= round_next;
        end
        w_reg <= w_next;
    end

    // little-endian bytes of the finished block
    assign ks_byte   = w_reg[ks_idx[5:2]][8*ks_idx[1:0] +: 8];
    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && (cw.op == cc20ks_pkg::OP_FINAL);

endmodule

`default_nettype wire

/* dv/cc20ks_checker.sv */
// checker for chacha20_keystream_xor: follows the key registers on the apb port, predicts
// every output byte from the accepted input items and compares in order
// depends on cc20ks_pkg for the key type and the address width
module cc20ks_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [71:0]                   s_tdata,  // data_byte[7:0], record_seq[71:8]
    input  logic                          s_tlast,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [7:0]                    m_tdata,  // out_byte[7:0]
    input  logic                          m_tlast,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cc20ks_pkg::ADDR_W-1:0] paddr,
    input  logic [63:0]                   pwdata,
    input  logic [63:0]                   prdata,
    input  logic                          pready,
    output int                            fails,
    output int                            pending,
    output int                            n_results,
    output int                            n_blocks,
    output int                            n_records
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DOUBLE_ROUNDS = 10;
    localparam int unsigned KEY_STRIDE    = 8;
    localparam int          MAX_REPORTS   = 100;

    localparam logic [31:0] EXPAND_0 = 32'h61707865;
    localparam logic [31:0] EXPAND_1 = 32'h3320646e;
    localparam logic [31:0] EXPAND_2 = 32'h79622d32;
    localparam logic [31:0] EXPAND_3 = 32'h6b206574;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } cipher_t;

    cipher_t             cipher_q[$];
    cc20ks_pkg::key_t    key_now;
    logic [511:0]        keystream;
    logic [31:0]         blk_ctr;
    logic [5:0]          blk_pos;
    logic [63:0]         seq_now;
    bit                  in_rec;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [15:0][31:0] quarter_round(input logic [15:0][31:0] w,
                                                        input int a, input int b,
                                                        input int c, input int d);
        logic [15:0][31:0] r;
        r = w;
        r[a] = r[a] + r[b]; r[d] = rotl(r[d] ^ r[a], 16);
        r[c] = r[c] + r[d]; r[b] = rotl(r[b] ^ r[c], 12);
        r[a] = r[a] + r[b]; r[d] = rotl(r[d] ^ r[a], 8);
        r[c] = r[c] + r[d]; r[b] = rotl(r[b] ^ r[c], 7);
        return r;
    endfunction

    // 64 keystream bytes, byte n in bits 8n+7:8n
    function automatic logic [511:0] ks_block(input cc20ks_pkg::key_t k,
                                              input logic [31:0] ctr,
                                              input logic [63:0] seq);
        logic [15:0][31:0] init_w;
        logic [15:0][31:0] w;
        logic [511:0]      ks;
        int                i;
        init_w[0] = EXPAND_0;
        init_w[1] = EXPAND_1;
        init_w[2] = EXPAND_2;
        init_w[3] = EXPAND_3;
        for (i = 0; i < 4; i++) begin
            init_w[4 + 2 * i] = k[i][31:0];
            init_w[5 + 2 * i] = k[i][63:32];
        end
        init_w[12] = ctr;
        init_w[13] = 32'h0;
        init_w[14] = seq[31:0];
        init_w[15] = seq[63:32];
        w = init_w;
        for (i = 0; i < int'(DOUBLE_ROUNDS); i++) begin
            w = quarter_round(w, 0, 4, 8, 12);
            w = quarter_round(w, 1, 5, 9, 13);
            w = quarter_round(w, 2, 6, 10, 14);
            w = quarter_round(w, 3, 7, 11, 15);
            w = quarter_round(w, 0, 5, 10, 15);
            w = quarter_round(w, 1, 6, 11, 12);
            w = quarter_round(w, 2, 7, 8, 13);
            w = quarter_round(w, 3, 4, 9, 14);
        end
        for (i = 0; i < 16; i++) begin
            ks[32 * i +: 32] = w[i] + init_w[i];
        end
        return ks;
    endfunction

    task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
        fails++;
        if (fails <= MAX_REPORTS) begin
            $display("%0t: %s: expected %0h, got %0h", $time, what, want, got);
        end else if (fails == MAX_REPORTS + 1) begin
            $display("%0t: further mismatches counted but not shown", $time);
        end
    endtask

    initial begin
        fails     = 0;
        n_results = 0;
        n_blocks  = 0;
        n_records = 0;
        pending   = 0;
    end

    always @(posedge aclk) begin : score
        cipher_t     want;
        int unsigned idx;
        if (!aresetn) begin
            key_now = '0;
            blk_ctr = '0;
            blk_pos = '0;
            seq_now = '0;
            in_rec  = 1'b0;
            cipher_q.delete();
            pending <= 0;
        end else begin
            if (psel && penable && pready) begin
                idx = paddr / KEY_STRIDE;
                if (pwrite) begin
                    if (idx < cc20ks_pkg::KEY_REGS) key_now[idx[1:0]] = pwdata;
                end else if (idx < cc20ks_pkg::KEY_REGS && prdata !== key_now[idx[1:0]]) begin
                    report($sformatf("key register %0d read back", idx),
                           key_now[idx[1:0]], prdata);
                end
            end

            if (s_tvalid && s_tready) begin
                // first item of a record takes the sequence number and restarts the counter
                if (!in_rec) begin
                    seq_now = s_tdata[71:8];
                    blk_ctr = '0;
                    blk_pos = '0;
                    in_rec  = 1'b1;
                    n_records++;
                end
                if (blk_pos == 0) begin
                    keystream = ks_block(key_now, blk_ctr, seq_now);
                    blk_ctr   = blk_ctr + 32'd1;
                    n_blocks++;
                end
                want.data = s_tdata[7:0] ^ keystream[8 * blk_pos +: 8];
                want.last = s_tlast;
                cipher_q.push_back(want);
                blk_pos = blk_pos + 6'd1;
                if (s_tlast) begin
                    in_rec  = 1'b0;
                    blk_ctr = '0;
                    blk_pos = '0;
                end
            end

            if (m_tvalid && m_tready) begin
                if (cipher_q.size() == 0) begin
                    report("result with no item outstanding", '0, 64'({m_tlast, m_tdata}));
                end else begin
                    want = cipher_q.pop_front();
                    n_results++;
                    if (m_tdata !== want.data) begin
                        report("out_byte", 64'(want.data), 64'(m_tdata));
                    end
                    if (m_tlast !== want.last) begin
                        report("out_last", 64'(want.last), 64'(m_tlast));
                    end
                end
            end
            pending <= cipher_q.size();
        end
    end
endmodule

/* dv/tb.sv */
// top of the chacha20_keystream_xor testbench: clock, reset, apb key programming,
// record stimulus with random gaps and stalls, watchdog and verdict
// depends on the rtl, cc20ks_pkg and cc20ks_checker
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS          = 1400;
    localparam int KEY_STRIDE     = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int TAIL_CYCLES    = 120;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [71:0]                   s_tdata;
    logic                          s_tlast;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [7:0]                    m_tdata;
    logic                          m_tlast;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [cc20ks_pkg::ADDR_W-1:0] paddr;
    logic [63:0]                   pwdata;
    logic [63:0]                   prdata;
    logic                          pready;

    int chk_fails;
    int chk_pending;
    int chk_results;
    int chk_blocks;
    int chk_records;

    int n_sent;
    int n_key_writes;
    int rec_left;
    int quiet;
    bit rx_random;
    bit hold_req;

    chacha20_keystream_xor u_top (.*);

    cc20ks_checker u_chk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .fails     (chk_fails),
        .pending   (chk_pending),
        .n_results (chk_results),
        .n_blocks  (chk_blocks),
        .n_records (chk_records)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 94) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // lengths cluster near the 64-byte block boundaries
    function automatic int record_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return $urandom_range(1, 4);
        if (r < 60) return $urandom_range(5, 63);
        if (r < 75) return 63 + $urandom_range(0, 2) + 64 * $urandom_range(0, 1);
        if (r < 90) return $urandom_range(66, 190);
        return $urandom_range(191, 400);
    endfunction

    task automatic apb_write(input int idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= cc20ks_pkg::ADDR_W'(idx * KEY_STRIDE);
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_key_writes++;
        @(posedge aclk);
    endtask

    task automatic apb_read(input int idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= cc20ks_pkg::ADDR_W'(idx * KEY_STRIDE);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_item(input logic [7:0] data, input logic [63:0] seq,
                             input logic last, input bit gaps);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {seq, data};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        n_sent++;
        if (gaps && $urandom_range(0, 2) == 0) begin
            gap = idle_cycles();
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // record_seq is random on every item; only a record's first one should matter
    task automatic send_random(input bit gaps);
        logic [7:0]  data;
        logic [63:0] seq;
        int          r;
        if (rec_left == 0) rec_left = record_len();
        r = $urandom_range(0, 15);
        data = (r == 0) ? 8'h00 : (r == 1) ? 8'hff : 8'($urandom);
        seq  = (r == 2) ? '0 : (r == 3) ? '1 : {$urandom, $urandom};
        send_item(data, seq, rec_left == 1, gaps);
        rec_left--;
    endtask

    task automatic wait_drained();
        do @(posedge aclk); while (chk_pending != 0);
    endtask

    task automatic program_key(input int phase);
        logic [63:0] words[4];
        int          i;
        int          idx;
        for (i = 0; i < 4; i++) words[i] = {$urandom, $urandom};
        case (phase % 5)
            0: begin
                for (i = 0; i < 4; i++) apb_write(i, words[i]);
            end
            1: begin
                for (i = 0; i < 4; i++) apb_write(i, '1);
            end
            2: begin
                for (i = 0; i < 4; i++) apb_write(i, '0);
            end
            3: begin
                idx = $urandom_range(0, 3);
                apb_write(idx, words[idx]);
            end
            default: begin
                for (i = 0; i < 4; i++) begin
                    apb_write(i, {32{2'b01}} ^ (64'd1 << $urandom_range(0, 63)));
                end
            end
        endcase
        apb_read($urandom_range(0, 3));
    endtask

    // receiver: random stalls, or a long hold-off on request
    initial begin
        m_tready <= 1'b0;
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if (rx_random && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat (idle_cycles()) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, quiet, chk_pending);
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin : stimulus
        int i;
        int phase;
        int count;
        int fails;
        bit gaps;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        quiet    = 0;
        n_sent   = 0;
        n_key_writes = 0;
        rec_left  = 0;
        rx_random = 1'b1;
        hold_req  = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero key: one-byte records at the extremes and in alternating patterns, then a short record
        for (i = 0; i < 4; i++) apb_write(i, '0);
        apb_read(0);
        send_item(8'h00, 64'h0, 1'b1, 1'b0);
        send_item(8'hff, '1, 1'b1, 1'b0);
        send_item(8'h55, {32{2'b01}}, 1'b1, 1'b0);
        send_item(8'haa, {32{2'b10}}, 1'b1, 1'b0);
        send_item(8'h00, 64'h0000_0001_0000_0000, 1'b0, 1'b0);
        send_item(8'hff, '1, 1'b0, 1'b0);
        send_item(8'h0f, 64'h0, 1'b0, 1'b0);
        send_item(8'hf0, {$urandom, $urandom}, 1'b0, 1'b0);
        send_item(8'h80, {$urandom, $urandom}, 1'b1, 1'b0);
        s_tvalid <= 1'b0;
        wait_drained();

        // all-ones key; the record left open here crosses the next key change
        for (i = 0; i < 4; i++) apb_write(i, '1);
        apb_read(3);
        send_item(8'h00, 64'h0, 1'b1, 1'b0);
        send_item(8'hff, '1, 1'b1, 1'b0);
        send_item(8'h01, 64'h0123_4567_89ab_cdef, 1'b0, 1'b0);
        send_item(8'hfe, 64'h0, 1'b0, 1'b0);
        send_item(8'h7f, '1, 1'b0, 1'b0);
        s_tvalid <= 1'b0;
        wait_drained();

        phase = 0;
        while (n_sent < ITEMS) begin
            program_key(phase);
            count     = $urandom_range(60, 240);
            gaps      = (phase % 3 != 0);
            rx_random = (phase % 4 != 2);
            if (phase == 1) begin
                // receiver holds off while items keep coming back to back
                gaps     = 1'b0;
                hold_req = 1'b1;
            end
            repeat (count) send_random(gaps);
            s_tvalid <= 1'b0;
            wait_drained();
            phase++;
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        fails = chk_fails;
        if (chk_pending != 0) begin
            $display("%0t: %0d results never arrived", $time, chk_pending);
            fails++;
        end
        $display("sent %0d items over %0d records, %0d keystream blocks, %0d results checked",
                 n_sent, chk_records, chk_blocks, chk_results);
        $display("%0d key register writes across %0d key settings", n_key_writes, phase + 2);
        if (fails == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
